// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the density heatmap.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition must hold at every clock edge outside reset.
`define BDH_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("heatmap assertion failed");
// Antecedent at one edge implies the consequent at the next edge.
`define BDH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heatmap assertion failed");
`endif

// File: hdl/bdh_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the block density heatmap.
package bdh_pkg;

   localparam int INDEX_BITS     = 24;
   localparam int PARTS_W        = 7;
   localparam int DIM_W          = 25;
   localparam int BIN_W          = 6;
   localparam int HEAT_W         = 17;
   localparam int FRAC_BITS      = 16;
   localparam int CMD_W          = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int MAX_PARTS_DEF  = 64;
   localparam int COUNT_BITS_DEF = 32;

   // Dividend width of the shared divider: covers positions and the row count.
   localparam int DVD_W  = (INDEX_BITS > DIM_W) ? INDEX_BITS : DIM_W;
   localparam int STEP_W = $clog2(DVD_W + 1);

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PART_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_COLS = 2'd2;

   localparam logic [HEAT_W-1:0] HEAT_ONE = HEAT_W'(1 << FRAC_BITS);

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [INDEX_BITS-1:0] row_pos;
      logic [INDEX_BITS-1:0] col_pos;
      logic [BIN_W-1:0]      read_row;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]  bin_row;
      logic [BIN_W-1:0]  bin_col;
      logic [HEAT_W-1:0] heat;
      logic              bad_config;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic frac;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// File: hdl/block_density_heatmap.sv
// Top level of the block density heatmap: sequencer, registers and output stage.
// req_* carries commands (add entry, read one grid row, clear grid), taken when
// req_valid is high and req_stall is low; req_stall is high while a command runs.
// csr_* writes the part count, matrix_rows and matrix_cols; csr_ready is always high.
// rsp_* returns one heat value per grid column on a read, last marks the final one.
// One restoring divider is shared by all steps and yields one quotient bit a cycle.
// Add: two 25-step position divisions plus memory read and write, with the input
// stalled throughout; the first add after a configuration write first runs a
// block-size division of the row count by the part count.
// Read: per column, the 16-bit fraction division is skipped when the entry total
// is zero or the cell holds all entries, and runs otherwise.
// Clear: one cell per cycle over all 2^(2*PART_BITS) grid cells (4096 at the
// default); the same clearing pass runs after reset before the first
// command is taken.
// The result register lets a command be accepted while the last result still
// waits; a read holds on its next column while rsp_stall is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module block_density_heatmap import bdh_pkg::*; #(
   parameter int MAX_PARTS  = MAX_PARTS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int PART_BITS = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int ADDR_W    = 2 * PART_BITS;
   localparam int PCNT_W    = $clog2(MAX_PARTS + 1);
   localparam int DVS_W     = (COUNT_BITS > DIM_W) ? COUNT_BITS : DIM_W;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_BSIZE  = 4'd2;
   localparam logic [3:0] S_ROWDIV = 4'd3;
   localparam logic [3:0] S_COLDIV = 4'd4;
   localparam logic [3:0] S_MEMRD  = 4'd5;
   localparam logic [3:0] S_UPD    = 4'd6;
   localparam logic [3:0] S_HRD    = 4'd7;
   localparam logic [3:0] S_HWAIT  = 4'd8;
   localparam logic [3:0] S_HDIV   = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + COUNT_BITS'(1);
   endfunction

   logic [3:0]            state_ff, state_in;
   logic [PARTS_W-1:0]    np_ff, np_in;
   logic [DIM_W-1:0]      rows_ff, rows_in;
   logic [DIM_W-1:0]      cols_ff, cols_in;
   logic [DIM_W-1:0]      bsize_ff, bsize_in;
   logic                  bsize_ok_ff, bsize_ok_in;
   logic [INDEX_BITS-1:0] row_pos_ff, row_pos_in;
   logic [INDEX_BITS-1:0] col_pos_ff, col_pos_in;
   logic [PART_BITS-1:0]  br_ff, br_in;
   logic [PART_BITS-1:0]  bc_ff, bc_in;
   logic [PART_BITS-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  go_ff, go_in;
   logic [HEAT_W-1:0]     heat_ff, heat_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [PCNT_W-1:0]     parts;
   logic [PART_BITS-1:0]  last_part;
   logic                  bad;
   logic [PART_BITS-1:0]  q_clamped;
   logic [PART_BITS-1:0]  rr;
   logic                  rsp_load;

   div_cmd_type           div_cmd;
   div_sts_type           div_sts;
   logic [DVS_W-1:0]      div_rem_init;
   logic [DVD_W-1:0]      div_dividend;
   logic [DVS_W-1:0]      div_divisor;
   logic [DVD_W-1:0]      div_quotient;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [COUNT_BITS-1:0] rd_data;

   // Effective parts: zero acts as one, above MAX_PARTS acts as MAX_PARTS.
   always_comb begin
      if (np_ff == '0) begin
         parts = PCNT_W'(1);
      end else if (32'(np_ff) > 32'(MAX_PARTS)) begin
         parts = PCNT_W'(MAX_PARTS);
      end else begin
         parts = PCNT_W'(np_ff);
      end
   end

   assign last_part = PART_BITS'(parts - PCNT_W'(1));
   assign bad       = (DIM_W'(parts) > rows_ff) || (DIM_W'(parts) > cols_ff);
   assign q_clamped = (div_quotient >= DVD_W'(parts)) ? last_part
                                                      : PART_BITS'(div_quotient);
   assign rr        = (32'(req_data.read_row) >= 32'(parts)) ? last_part
                                                             : PART_BITS'(req_data.read_row);
   assign rsp_load  = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Divider operands follow the step in progress.
   always_comb begin
      div_cmd.start = go_ff;
      div_cmd.frac  = 1'b0;
      div_rem_init  = '0;
      div_dividend  = DVD_W'(row_pos_ff);
      div_divisor   = DVS_W'(bsize_ff);
      case (state_ff)
         S_BSIZE: begin
            div_dividend = DVD_W'(rows_ff);
            div_divisor  = DVS_W'(parts);
         end
         S_COLDIV: begin
            div_dividend = DVD_W'(col_pos_ff);
         end
         S_HDIV: begin
            div_cmd.frac = 1'b1;
            div_rem_init = DVS_W'(rd_data);
            div_dividend = '0;
            div_divisor  = DVS_W'(total_ff);
         end
         default: begin
            div_dividend = DVD_W'(row_pos_ff);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      np_in        = np_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      bsize_in     = bsize_ff;
      bsize_ok_in  = bsize_ok_ff;
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      br_in        = br_ff;
      bc_in        = bc_ff;
      col_in       = col_ff;
      clr_in       = clr_ff;
      total_in     = total_ff;
      go_in        = 1'b0;
      heat_in      = heat_ff;
      wr_en        = 1'b0;
      wr_addr      = {br_ff, bc_ff};
      wr_data      = sat_inc(rd_data);
      rd_en        = 1'b0;
      rd_addr      = {br_ff, bc_ff};

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  CMD_ADD: begin
                     // drop the entry under a bad configuration
                     if (!bad) begin
                        row_pos_in = req_data.row_pos;
                        col_pos_in = req_data.col_pos;
                        go_in      = 1'b1;
                        state_in   = bsize_ok_ff ? S_ROWDIV : S_BSIZE;
                     end
                  end
                  CMD_READ: begin
                     br_in    = rr;
                     col_in   = '0;
                     state_in = S_HRD;
                  end
                  CMD_CLEAR: begin
                     total_in = '0;
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_BSIZE: begin
            if (div_sts.done) begin
               bsize_in    = DIM_W'(div_quotient);
               bsize_ok_in = 1'b1;
               go_in       = 1'b1;
               state_in    = S_ROWDIV;
            end
         end
         S_ROWDIV: begin
            if (div_sts.done) begin
               br_in    = q_clamped;
               go_in    = 1'b1;
               state_in = S_COLDIV;
            end
         end
         S_COLDIV: begin
            if (div_sts.done) begin
               bc_in    = q_clamped;
               state_in = S_MEMRD;
            end
         end
         S_MEMRD: begin
            rd_en    = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            wr_en    = 1'b1;
            total_in = sat_inc(total_ff);
            state_in = S_IDLE;
         end
         S_HRD: begin
            rd_en    = 1'b1;
            rd_addr  = {br_ff, col_ff};
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (total_ff == '0) begin
               heat_in  = '0;
               state_in = S_EMIT;
            end else if (rd_data >= total_ff) begin
               heat_in  = HEAT_ONE;
               state_in = S_EMIT;
            end else begin
               go_in    = 1'b1;
               state_in = S_HDIV;
            end
         end
         S_HDIV: begin
            if (div_sts.done) begin
               heat_in  = HEAT_W'(div_quotient[FRAC_BITS-1:0]);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               if (col_ff == last_part) begin
                  state_in = S_IDLE;
               end else begin
                  col_in   = col_ff + PART_BITS'(1);
                  state_in = S_HRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The user must make register writes only while idle, unenforced here; any write forces a new block size.
      if (csr_valid) begin
         bsize_ok_in = 1'b0;
         case (csr_index)
            CSR_PART_COUNT:  np_in   = csr_wdata[PARTS_W-1:0];
            CSR_MATRIX_ROWS: rows_in = csr_wdata;
            CSR_MATRIX_COLS: cols_in = csr_wdata;
            default:         np_in   = np_ff;
         endcase
      end
   end

   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.bin_row    = BIN_W'(br_ff);
         rsp_in.bin_col    = BIN_W'(col_ff);
         rsp_in.heat       = heat_ff;
         rsp_in.bad_config = bad;
         rsp_in.last       = (col_ff == last_part);
         rsp_valid_in      = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         np_ff        <= PARTS_W'(1);
         rows_ff      <= DIM_W'(1);
         cols_ff      <= DIM_W'(1);
         bsize_ok_ff  <= 1'b0;
         clr_ff       <= '0;
         total_ff     <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         np_ff        <= np_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         bsize_ok_ff  <= bsize_ok_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bsize_ff   <= bsize_in;
      row_pos_ff <= row_pos_in;
      col_pos_ff <= col_pos_in;
      br_ff      <= br_in;
      bc_ff      <= bc_in;
      col_ff     <= col_in;
      heat_ff    <= heat_in;
      rsp_ff     <= rsp_in;
   end

   bdh_div #(
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_sts  (div_sts),
      .quotient (div_quotient)
   );

   bdh_grid #(
      .ADDR_W (ADDR_W),
      .DATA_W (COUNT_BITS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `BDH_ASSERT_NEXT(a_rsp_only_from_emit, (state_ff != S_EMIT) && !rsp_valid_ff, !rsp_valid_ff)
   `BDH_ASSERT_ALWAYS(a_div_start_when_free, !(div_cmd.start && div_sts.busy))
   `BDH_ASSERT_ALWAYS(a_heat_in_range, !rsp_valid_ff || (rsp_ff.heat <= HEAT_ONE))

endmodule

// File: hdl/bdh_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
module bdh_div import bdh_pkg::*; #(
   parameter int DVS_W = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  div_cmd_type       div_cmd,
   input  logic [DVS_W-1:0]  rem_init,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DVS_W-1:0]  divisor,
   output div_sts_type       div_sts,
   output logic [DVD_W-1:0]  quotient
);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = (trial >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_cmd.start) begin
         rem_in  = rem_init;
         quo_in  = dividend;
         dvs_in  = divisor;
         // fractional mode only shifts in the Q0.16 bits below the remainder
         step_in = div_cmd.frac ? STEP_W'(FRAC_BITS) : STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign quotient     = quo_ff;

endmodule

// File: hdl/bdh_grid.sv
`timescale 1ns / 1ps
// Cell count memory: one write port, one registered read port.
module bdh_grid import bdh_pkg::*; #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
